@@ rtl/lpfp_pkg.sv @@
// Shared types, codes and constants of the length-prefixed frame parser.
package lpfp_pkg;

    // Result kinds
    localparam logic [2:0] RK_START  = 3'd0;
    localparam logic [2:0] RK_FSTART = 3'd1;
    localparam logic [2:0] RK_FBYTE  = 3'd2;
    localparam logic [2:0] RK_DONE   = 3'd3;
    localparam logic [2:0] RK_ERROR  = 3'd4;

    // Error codes
    localparam logic [2:0] EC_MAGIC = 3'd0;
    localparam logic [2:0] EC_LEN   = 3'd1;
    localparam logic [2:0] EC_FHDR  = 3'd2;
    localparam logic [2:0] EC_FLEN  = 3'd3;
    localparam logic [2:0] EC_TRAIL = 3'd4;

    // Input kinds
    localparam logic IN_BYTE    = 1'b0;
    localparam logic IN_RESTART = 1'b1;

    // Configuration port: register index is paddr[CFG_AW-1]
    localparam int         CFG_AW           = 3;
    localparam logic       REG_MAX_BODY_LEN = 1'b0;
    localparam logic [31:0] MAX_BODY_RESET  = 32'd10485760;

    // Smallest legal body: type, count and two reserved bytes
    localparam logic [31:0] BODY_HDR_BYTES = 32'd4;
    // A field header is a 32-bit length
    localparam logic [31:0] FIELD_HDR_BYTES = 32'd4;

    // Result queue sizing
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_BODYHDR = 4'b0010,
        PH_FHDR    = 4'b0100,
        PH_FDATA   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  msg_type;
        logic [7:0]  fcount;
        logic [7:0]  fnum;
        logic [31:0] flen;
        logic [7:0]  pbyte;
        logic        fend;
        logic [2:0]  ecode;
        logic        last;
    } result_t;

    // Core to result queue: up to two results per processed byte
    typedef struct packed {
        logic    wr0;
        logic    wr1;
        result_t res0;
        result_t res1;
    } oq_push_t;

    // Frame magic "IOBC"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = 8'h49;
            2'd1:    m = 8'h4F;
            2'd2:    m = 8'h42;
            default: m = 8'h43;
        endcase
        return m;
    endfunction

    function automatic result_t mk_result(
        input logic [2:0]  kind,
        input logic [7:0]  msg_type,
        input logic [7:0]  fcount,
        input logic [7:0]  fnum,
        input logic [31:0] flen,
        input logic [7:0]  pbyte,
        input logic        fend,
        input logic [2:0]  ecode
    );
        result_t r;
        r.kind     = kind;
        r.msg_type = msg_type;
        r.fcount   = fcount;
        r.fnum     = fnum;
        r.flen     = flen;
        r.pbyte    = pbyte;
        r.fend     = fend;
        r.ecode    = ecode;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/length_prefixed_frame_parser.sv @@
// A transferred byte is registered in the input holding register and parsed from
// there once the result queue has room; its results then join the queue.
// Throughput: one byte per cycle while each byte causes one result and the output is
// not stalled; the output port moves one result per cycle, so once the queue's spare
// slot is used, a byte that causes two results holds the input until there is room.
// Reset (rst_n, async low) empties the queue, awaits a frame header, loads 10 MiB.
module length_prefixed_frame_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [7:0]                  stream_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  result_kind,
    output logic [7:0]                  message_type,
    output logic [7:0]                  field_count,
    output logic [7:0]                  field_number,
    output logic [31:0]                 field_length,
    output logic [7:0]                  payload_byte,
    output logic                        field_end,
    output logic [2:0]                  error_code,
    output logic                        last
);
    import lpfp_pkg::*;

    logic [31:0] max_body_len;
    logic        oq_room;
    oq_push_t    oq_push;
    result_t     out_res;

    lpfp_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_body_len (max_body_len)
    );

    lpfp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .stream_byte  (stream_byte),
        .max_body_len (max_body_len),
        .oq_room      (oq_room),
        .oq_push      (oq_push)
    );

    lpfp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .oq_push   (oq_push),
        .oq_room   (oq_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign message_type = out_res.msg_type;
    assign field_count  = out_res.fcount;
    assign field_number = out_res.fnum;
    assign field_length = out_res.flen;
    assign payload_byte = out_res.pbyte;
    assign field_end    = out_res.fend;
    assign error_code   = out_res.ecode;
    assign last         = out_res.last;

endmodule

@@ rtl/lpfp_regs.sv @@
// APB configuration register: largest accepted body length.
module lpfp_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lpfp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [31:0]                max_body_len
);
    import lpfp_pkg::*;

    logic [31:0] max_body_len_reg;
    logic        sel_max;

    assign sel_max = (paddr[CFG_AW-1] == REG_MAX_BODY_LEN);

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_len_reg <= MAX_BODY_RESET;
        end
        else if (psel && penable && pwrite && sel_max)
        begin
            max_body_len_reg <= pwdata;
        end
    end

    assign prdata       = sel_max ? max_body_len_reg : 32'd0;
    assign pready       = 1'b1;
    assign max_body_len = max_body_len_reg;

endmodule

@@ rtl/lpfp_core.sv @@
// Input register and per-byte parse step: frame state and up to two results.
module lpfp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [7:0]         stream_byte,
    input  logic [31:0]        max_body_len,
    input  logic               oq_room,
    output lpfp_pkg::oq_push_t oq_push
);
    import lpfp_pkg::*;

    // Input holding register
    logic        hold_valid_reg;
    logic        hold_kind_reg;
    logic [7:0]  hold_byte_reg;
    logic        fire;

    // Parser state
    phase_t      phase_reg,  phase_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic        mgood_reg,  mgood_next;
    logic [31:0] ls_reg,     ls_next;
    logic [31:0] br_reg,     br_next;
    logic [7:0]  htype_reg,  htype_next;
    logic [7:0]  hcount_reg, hcount_next;
    logic [7:0]  fi_reg,     fi_next;
    logic [31:0] fr_reg,     fr_next;
    logic        halted_reg, halted_next;

    // Step temporaries
    result_t     res0, res1;
    logic        wr0, wr1;
    logic        np_go;
    logic [7:0]  np_fi;
    logic [31:0] np_br;
    logic [31:0] ls_shift;
    logic [31:0] br_dec;
    logic [31:0] fr_dec;
    logic [7:0]  fi_inc;

    assign fire     = hold_valid_reg && oq_room;
    assign in_stall = hold_valid_reg && !oq_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_kind_reg <= kind;
            hold_byte_reg <= stream_byte;
        end
    end

    assign ls_shift = {ls_reg[23:0], hold_byte_reg};
    assign br_dec   = br_reg - 32'd1;
    assign fr_dec   = fr_reg - 32'd1;
    assign fi_inc   = fi_reg + 8'd1;

    // One parse step
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mgood_next  = mgood_reg;
        ls_next     = ls_reg;
        br_next     = br_reg;
        htype_next  = htype_reg;
        hcount_next = hcount_reg;
        fi_next     = fi_reg;
        fr_next     = fr_reg;
        halted_next = halted_reg;
        res0        = '0;
        res1        = '0;
        wr0         = 1'b0;
        wr1         = 1'b0;
        np_go       = 1'b0;
        np_fi       = 8'd0;
        np_br       = 32'd0;

        if (fire && hold_kind_reg == IN_RESTART)
        begin
            phase_next  = PH_HEADER;
            cnt_next    = 3'd0;
            mgood_next  = 1'b1;
            ls_next     = 32'd0;
            br_next     = 32'd0;
            htype_next  = 8'd0;
            hcount_next = 8'd0;
            fi_next     = 8'd0;
            fr_next     = 32'd0;
            halted_next = 1'b0;
        end
        else if (fire && !halted_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // Magic bytes first, then big-endian body length
                    if (!cnt_reg[2])
                    begin
                        if (hold_byte_reg != magic_byte(cnt_reg[1:0]))
                        begin
                            mgood_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ls_next = ls_shift;
                    end
                    if (cnt_reg == 3'd7)
                    begin
                        if (!mgood_reg)
                        begin
                            res0 = mk_result(RK_ERROR, htype_reg, hcount_reg, 8'd0,
                                             32'd0, 8'd0, 1'b0, EC_MAGIC);
                            wr0 = 1'b1;
                            halted_next = 1'b1;
                        end
                        else if (ls_shift < BODY_HDR_BYTES || ls_shift > max_body_len)
                        begin
                            res0 = mk_result(RK_ERROR, htype_reg, hcount_reg, 8'd0,
                                             32'd0, 8'd0, 1'b0, EC_LEN);
                            wr0 = 1'b1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            br_next    = ls_shift;
                            phase_next = PH_BODYHDR;
                            cnt_next   = 3'd0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_BODYHDR:
                begin
                    br_next = br_dec;
                    if (cnt_reg == 3'd0)
                    begin
                        htype_next = hold_byte_reg;
                    end
                    if (cnt_reg == 3'd1)
                    begin
                        hcount_next = hold_byte_reg;
                    end
                    if (cnt_reg >= 3'd3)
                    begin
                        fi_next = 8'd0;
                        res0 = mk_result(RK_START, htype_reg, hcount_reg, 8'd0,
                                         32'd0, 8'd0, 1'b0, 3'd0);
                        wr0   = 1'b1;
                        np_go = 1'b1;
                        np_fi = 8'd0;
                        np_br = br_dec;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_FHDR:
                begin
                    br_next = br_dec;
                    ls_next = ls_shift;
                    if (cnt_reg >= 3'd3)
                    begin
                        if (ls_shift > br_dec)
                        begin
                            res0 = mk_result(RK_ERROR, htype_reg, hcount_reg, 8'd0,
                                             32'd0, 8'd0, 1'b0, EC_FLEN);
                            wr0 = 1'b1;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            res0 = mk_result(RK_FSTART, htype_reg, hcount_reg, fi_reg,
                                             ls_shift, 8'd0, 1'b0, 3'd0);
                            wr0     = 1'b1;
                            fr_next = ls_shift;
                            if (ls_shift == 32'd0)
                            begin
                                // Empty field completes at once
                                fi_next = fi_inc;
                                np_go   = 1'b1;
                                np_fi   = fi_inc;
                                np_br   = br_dec;
                            end
                            else
                            begin
                                phase_next = PH_FDATA;
                            end
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_FDATA:
                begin
                    br_next = br_dec;
                    fr_next = fr_dec;
                    res0 = mk_result(RK_FBYTE, htype_reg, hcount_reg, fi_reg, ls_reg,
                                     hold_byte_reg, (fr_dec == 32'd0), 3'd0);
                    wr0 = 1'b1;
                    if (fr_dec == 32'd0)
                    begin
                        fi_next = fi_inc;
                        np_go   = 1'b1;
                        np_fi   = fi_inc;
                        np_br   = br_dec;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            // What follows a finished body header or field; any result here is the second one
            if (np_go)
            begin
                if (np_fi >= hcount_next)
                begin
                    if (np_br == 32'd0)
                    begin
                        res1 = mk_result(RK_DONE, htype_next, hcount_next, 8'd0,
                                         32'd0, 8'd0, 1'b0, 3'd0);
                        wr1         = 1'b1;
                        phase_next  = PH_HEADER;
                        cnt_next    = 3'd0;
                        mgood_next  = 1'b1;
                        ls_next     = 32'd0;
                        br_next     = 32'd0;
                        htype_next  = 8'd0;
                        hcount_next = 8'd0;
                        fi_next     = 8'd0;
                        fr_next     = 32'd0;
                    end
                    else
                    begin
                        res1 = mk_result(RK_ERROR, htype_next, hcount_next, 8'd0,
                                         32'd0, 8'd0, 1'b0, EC_TRAIL);
                        wr1 = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                else if (np_br < FIELD_HDR_BYTES)
                begin
                    res1 = mk_result(RK_ERROR, htype_next, hcount_next, 8'd0,
                                     32'd0, 8'd0, 1'b0, EC_FHDR);
                    wr1 = 1'b1;
                    halted_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_FHDR;
                    cnt_next   = 3'd0;
                    ls_next    = 32'd0;
                end
            end

            // Mark the final result of this byte
            if (wr1)
            begin
                res1.last = 1'b1;
            end
            else
            begin
                res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            cnt_reg    <= 3'd0;
            mgood_reg  <= 1'b1;
            ls_reg     <= 32'd0;
            br_reg     <= 32'd0;
            htype_reg  <= 8'd0;
            hcount_reg <= 8'd0;
            fi_reg     <= 8'd0;
            fr_reg     <= 32'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            mgood_reg  <= mgood_next;
            ls_reg     <= ls_next;
            br_reg     <= br_next;
            htype_reg  <= htype_next;
            hcount_reg <= hcount_next;
            fi_reg     <= fi_next;
            fr_reg     <= fr_next;
            halted_reg <= halted_next;
        end
    end

    assign oq_push.wr0  = wr0;
    assign oq_push.wr1  = wr1;
    assign oq_push.res0 = res0;
    assign oq_push.res1 = res1;

endmodule

@@ rtl/lpfp_outq.sv @@
// Result queue: takes up to two results a cycle, delivers one per transfer.
module lpfp_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  lpfp_pkg::oq_push_t oq_push,
    output logic               oq_room,
    output logic               out_valid,
    input  logic               out_stall,
    output lpfp_pkg::result_t  out_res
);
    import lpfp_pkg::*;

    result_t            mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   head_reg;
    logic [OQ_AW-1:0]   tail_reg;
    logic [OQ_CW-1:0]   count_reg;
    logic               pop;
    logic [OQ_AW-1:0]   tail_inc;

    assign pop      = out_valid && !out_stall;
    assign tail_inc = tail_reg + OQ_AW'(1);

    // Room for a full two-result step
    assign oq_room   = (count_reg <= OQ_CW'(OQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push.wr0)
        begin
            mem_reg[tail_reg] <= oq_push.res0;
        end
        if (oq_push.wr1)
        begin
            mem_reg[tail_inc] <= oq_push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= head_reg + OQ_AW'(1);
            end
            tail_reg  <= tail_reg + OQ_AW'(oq_push.wr0) + OQ_AW'(oq_push.wr1);
            count_reg <= count_reg + OQ_CW'(oq_push.wr0) + OQ_CW'(oq_push.wr1)
                         - OQ_CW'(pop);
        end
    end

endmodule

@@ rtl/lpfp_chk.sv @@
// Port-level checker for the frame parser, bound to the top level.
module lpfp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  result_kind,
    input logic [7:0]  field_number,
    input logic [31:0] field_length,
    input logic [7:0]  payload_byte,
    input logic        field_end,
    input logic [2:0]  error_code,
    input logic        last
);
    import lpfp_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Error and message done always close out the byte's results
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RK_ERROR || result_kind == RK_DONE) |-> last)
        else $error("terminal result without last");

    // Only field bytes carry data and the field end flag
    a_fbyte_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_FBYTE |-> !field_end && payload_byte == 8'd0)
        else $error("data on a non-data result");

    // Field number and length only on field results
    a_field_info: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_FBYTE && result_kind != RK_FSTART
        |-> field_number == 8'd0 && field_length == 32'd0)
        else $error("field info on a non-field result");

    // Error code only on error results
    a_ecode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_ERROR |-> error_code == 3'd0)
        else $error("error code on a non-error result");

endmodule

bind length_prefixed_frame_parser lpfp_chk u_lpfp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .field_number (field_number),
    .field_length (field_length),
    .payload_byte (payload_byte),
    .field_end    (field_end),
    .error_code   (error_code),
    .last         (last)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the length-prefixed frame parser.
`timescale 1ns / 100ps

module tb_top;
    import lpfp_pkg::*;

    localparam logic [7:0]  FRAME_MAGIC [4] = '{8'h49, 8'h4F, 8'h42, 8'h43};
    localparam logic [31:0] BODY_LIMIT_RESET = 32'd10485760;
    localparam logic [31:0] MIN_BODY         = 32'd4;
    localparam logic [31:0] FIELD_HDR_LEN    = 32'd4;
    localparam logic [CFG_AW-1:0] MAX_LEN_ADDR = {REG_MAX_BODY_LEN, 2'b00};
    localparam int ITEM_TARGET = 1650;
    localparam int STUCK_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {
        DEF_NONE, DEF_MAGIC, DEF_LEN, DEF_FHDR, DEF_FLEN, DEF_TRAIL, DEF_TRUNC
    } defect_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = IN_BYTE;
    logic [7:0]          stream_byte = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          result_kind;
    logic [7:0]          message_type;
    logic [7:0]          field_count;
    logic [7:0]          field_number;
    logic [31:0]         field_length;
    logic [7:0]          payload_byte;
    logic                field_end;
    logic [2:0]          error_code;
    logic                last;

    length_prefixed_frame_parser dut (.*);

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Parser shadow state
    logic [31:0] body_limit;
    phase_t      p_phase;
    logic [2:0]  p_cnt;
    logic        p_magic_ok;
    logic [31:0] p_shift;
    logic [31:0] p_body_left;
    logic [7:0]  p_type;
    logic [7:0]  p_count;
    logic [7:0]  p_field;
    logic [31:0] p_field_left;
    logic        p_halted;

    result_t     staged;
    bit          staged_valid;
    result_t     expected_results[$];
    result_t     want;

    logic [7:0]  frame_q[$];
    int          items_sent = 0;
    int          mismatches = 0;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_req = 0;
    int          rx_hold_left = 0;
    int          rx_run = 0;
    logic        rx_stall_now;
    int          stuck_cycles = 0;

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_frame();
        p_phase      = PH_HEADER;
        p_cnt        = '0;
        p_magic_ok   = 1'b1;
        p_shift      = '0;
        p_body_left  = '0;
        p_type       = '0;
        p_count      = '0;
        p_field      = '0;
        p_field_left = '0;
    endfunction

    // Stage one result; the last one of an input gets its last flag at the end
    function automatic void note_result(input logic [2:0] rk, input logic [7:0] fnum,
                                        input logic [31:0] flen, input logic [7:0] pb,
                                        input logic fe, input logic [2:0] ec);
        if (staged_valid)
            expected_results.insert(expected_results.size(), staged);
        staged.kind     = rk;
        staged.msg_type = p_type;
        staged.fcount   = p_count;
        staged.fnum     = fnum;
        staged.flen     = flen;
        staged.pbyte    = pb;
        staged.fend     = fe;
        staged.ecode    = ec;
        staged.last     = 1'b0;
        staged_valid    = 1'b1;
    endfunction

    function automatic void raise_error(input logic [2:0] ec);
        note_result(RK_ERROR, '0, '0, '0, 1'b0, ec);
        p_halted = 1'b1;
    endfunction

    // After the body header or a field: done, next field header, or early error
    function automatic void after_part();
        if (p_field >= p_count)
        begin
            if (p_body_left == 0)
            begin
                note_result(RK_DONE, '0, '0, '0, 1'b0, '0);
                clear_frame();
            end
            else
                raise_error(EC_TRAIL);
        end
        else if (p_body_left < FIELD_HDR_LEN)
            raise_error(EC_FHDR);
        else
        begin
            p_phase = PH_FHDR;
            p_cnt   = '0;
            p_shift = '0;
        end
    endfunction

    // Expected results of one accepted input item
    function automatic void parse_byte(input logic k, input logic [7:0] b);
        staged_valid = 1'b0;
        if (k == IN_RESTART)
        begin
            p_halted = 1'b0;
            clear_frame();
            return;
        end
        if (p_halted)
            return;
        case (p_phase)
            PH_HEADER:
            begin
                if (p_cnt < 4)
                begin
                    if (b != FRAME_MAGIC[p_cnt[1:0]])
                        p_magic_ok = 1'b0;
                end
                else
                    p_shift = {p_shift[23:0], b};
                if (p_cnt == 7)
                begin
                    if (!p_magic_ok)
                        raise_error(EC_MAGIC);
                    else if (p_shift < MIN_BODY || p_shift > body_limit)
                        raise_error(EC_LEN);
                    else
                    begin
                        p_body_left = p_shift;
                        p_phase     = PH_BODYHDR;
                        p_cnt       = '0;
                    end
                end
                else
                    p_cnt++;
            end
            PH_BODYHDR:
            begin
                p_body_left--;
                if (p_cnt == 0)
                    p_type = b;
                else if (p_cnt == 1)
                    p_count = b;
                if (p_cnt >= 3)
                begin
                    p_field = '0;
                    note_result(RK_START, '0, '0, '0, 1'b0, '0);
                    after_part();
                end
                else
                    p_cnt++;
            end
            PH_FHDR:
            begin
                p_body_left--;
                p_shift = {p_shift[23:0], b};
                if (p_cnt >= 3)
                begin
                    if (p_shift > p_body_left)
                        raise_error(EC_FLEN);
                    else
                    begin
                        note_result(RK_FSTART, p_field, p_shift, '0, 1'b0, '0);
                        p_field_left = p_shift;
                        if (p_field_left == 0)
                        begin
                            p_field++;
                            after_part();
                        end
                        else
                            p_phase = PH_FDATA;
                    end
                end
                else
                    p_cnt++;
            end
            default:
            begin
                p_body_left--;
                p_field_left--;
                note_result(RK_FBYTE, p_field, p_shift, b, p_field_left == 0, '0);
                if (p_field_left == 0)
                begin
                    p_field++;
                    after_part();
                end
            end
        endcase
        if (staged_valid)
        begin
            staged.last = 1'b1;
            expected_results.insert(expected_results.size(), staged);
        end
    endfunction

    // Frame construction
    function automatic void add_byte(input logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    function automatic void put_word(input logic [31:0] v);
        add_byte(v[31:24]);
        add_byte(v[23:16]);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
    endfunction

    function automatic void build_message(input int nflds, input int minlen,
                                          input int maxlen, input defect_t defect);
        int          i;
        int          j;
        int          flen;
        int          pos;
        int          keep;
        int          nf;
        logic [31:0] blen;
        logic [7:0]  cnt_byte;
        nf = (defect == DEF_FLEN && nflds == 0) ? 1 : nflds;
        frame_q.delete();
        for (i = 0; i < 4; i++)
            add_byte(FRAME_MAGIC[i]);
        put_word('0);
        add_byte(8'($urandom_range(0, 255)));
        cnt_byte = 8'(nf);
        if (defect == DEF_FHDR)
            cnt_byte = ($urandom_range(0, 5) == 0) ? 8'd255
                                                   : 8'(nf + $urandom_range(1, 3));
        add_byte(cnt_byte);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        for (i = 0; i < nf; i++)
        begin
            flen = $urandom_range(minlen, maxlen);
            if (defect == DEF_FLEN && i == nf - 1)
            begin
                if ($urandom_range(0, 1))
                    put_word(flen + $urandom_range(1, 8));
                else
                    put_word($urandom | 32'h8000_0000);
            end
            else
                put_word(flen);
            for (j = 0; j < flen; j++)
                add_byte(8'($urandom_range(0, 255)));
        end
        if (defect == DEF_TRAIL)
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        else if (defect == DEF_FHDR && $urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        blen = frame_q.size() - 8;
        if (defect == DEF_LEN)
        begin
            case ($urandom_range(0, 2))
                0: blen = $urandom_range(0, 3);
                1: blen = (body_limit < 32'hFFFF_FFF0) ? body_limit + $urandom_range(1, 4)
                                                       : $urandom_range(0, 3);
                default: blen = $urandom;
            endcase
        end
        frame_q[4] = blen[31:24];
        frame_q[5] = blen[23:16];
        frame_q[6] = blen[15:8];
        frame_q[7] = blen[7:0];
        if (defect == DEF_MAGIC)
        begin
            pos = $urandom_range(0, 3);
            frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
        end
        if (defect == DEF_TRUNC)
        begin
            keep = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
    endfunction

    // Offer one item and wait for its transfer; called and returns at a falling edge
    task automatic send_item(input logic k, input logic [7:0] b);
        if ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        stream_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        parse_byte(k, b);
        @(negedge clk);
    endtask

    task automatic send_bytes();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_item(IN_BYTE, frame_q[i]);
    endtask

    // Bring the parser back to header search after a broken or cut frame
    task automatic recover(input defect_t defect);
        if (defect != DEF_NONE || p_halted)
        begin
            if (p_halted && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(IN_BYTE, 8'($urandom_range(0, 255)));
            send_item(IN_RESTART, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_frame(input int nflds, input int minlen, input int maxlen,
                              input defect_t defect);
        build_message(nflds, minlen, maxlen, defect);
        send_bytes();
        recover(defect);
    endtask

    // Wait until the block is idle before touching the register
    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_LEN_ADDR;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        body_limit = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MAX_LEN_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== body_limit)
        begin
            $error("max_body_len: expected %0h, actual %0h", body_limit, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_message(input int defect_pct);
        defect_t defect;
        int      nflds;
        int      maxlen;
        defect = ($urandom_range(0, 99) < defect_pct) ? defect_t'($urandom_range(1, 6))
                                                      : DEF_NONE;
        case ($urandom_range(0, 9))
            0: begin nflds = $urandom_range(5, 20); maxlen = 2; end
            1: begin nflds = $urandom_range(0, 2); maxlen = 40; end
            default: begin nflds = $urandom_range(0, 4); maxlen = 8; end
        endcase
        send_frame(nflds, 0, maxlen, defect);
    endtask

    // Empty message, then a header that is wrong in both magic and length
    task automatic test_directed_edges();
        frame_q.delete();
        foreach (FRAME_MAGIC[i])
            add_byte(FRAME_MAGIC[i]);
        put_word(MIN_BODY);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h00);
        send_bytes();
        frame_q.delete();
        add_byte(8'h00);
        add_byte(FRAME_MAGIC[1]);
        add_byte(FRAME_MAGIC[2]);
        add_byte(FRAME_MAGIC[3]);
        put_word('0);
        send_bytes();
        // ignored while halted
        send_item(IN_BYTE, 8'hFF);
        send_item(IN_RESTART, 8'h5A);
    endtask

    task automatic test_well_formed();
        tx_gap_pct   = 25;
        rx_stall_pct = 25;
        while (items_sent < 650)
            random_message(0);
    endtask

    task automatic test_broken_frames();
        tx_gap_pct   = 15;
        rx_stall_pct = 45;
        while (items_sent < 1100)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // line noise with the odd restart
                repeat ($urandom_range(4, 20))
                    send_item($urandom_range(0, 7) == 0 ? IN_RESTART : IN_BYTE,
                              8'($urandom_range(0, 255)));
                send_item(IN_RESTART, 8'($urandom_range(0, 255)));
            end
            else
                random_message(70);
        end
    endtask

    // Body length bound at several register settings, extremes included
    task automatic test_length_limits();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        quiesce();
        cfg_check();
        cfg_write(MIN_BODY);
        cfg_check();
        send_frame(0, 0, 0, DEF_NONE);
        send_frame(1, 0, 0, DEF_NONE);
        send_frame(0, 0, 0, DEF_TRAIL);
        quiesce();
        cfg_write(32'd24);
        cfg_check();
        send_frame(1, 16, 16, DEF_NONE);
        send_frame(1, 17, 17, DEF_NONE);
        repeat (6) send_frame($urandom_range(0, 3), 0, 5, DEF_NONE);
        quiesce();
        cfg_write(32'hFFFF_FFFF);
        cfg_check();
        repeat (3) random_message(0);
        repeat (3) send_frame($urandom_range(0, 3), 0, 6, DEF_LEN);
        quiesce();
        cfg_write($urandom_range(8, 200));
        cfg_check();
        repeat (6) random_message(30);
        quiesce();
        cfg_write(BODY_LIMIT_RESET);
        cfg_check();
    endtask

    // Receiver holds off long enough for the parser to stall its input
    task automatic test_output_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 400;
        repeat (6) send_frame(2, 2, 6, DEF_NONE);
    endtask

    task automatic test_back_to_back();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        while (items_sent < ITEM_TARGET)
            random_message(20);
    endtask

    // Receiver stall generator
    always @(negedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            rx_stall_now = 1'b1;
        end
        else if (rx_run > 0)
        begin
            rx_run--;
            rx_stall_now = 1'b1;
        end
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            rx_run       = idle_len() - 1;
            rx_stall_now = 1'b1;
        end
        else
            rx_stall_now = 1'b0;
        out_stall <= rx_stall_now;
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result_kind: expected none, actual %0d", result_kind);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                    mismatches++;
                end
                if (message_type !== want.msg_type)
                begin
                    $error("message_type: expected %0h, actual %0h", want.msg_type,
                           message_type);
                    mismatches++;
                end
                if (field_count !== want.fcount)
                begin
                    $error("field_count: expected %0d, actual %0d", want.fcount, field_count);
                    mismatches++;
                end
                if (field_number !== want.fnum)
                begin
                    $error("field_number: expected %0d, actual %0d", want.fnum, field_number);
                    mismatches++;
                end
                if (field_length !== want.flen)
                begin
                    $error("field_length: expected %0h, actual %0h", want.flen, field_length);
                    mismatches++;
                end
                if (payload_byte !== want.pbyte)
                begin
                    $error("payload_byte: expected %0h, actual %0h", want.pbyte, payload_byte);
                    mismatches++;
                end
                if (field_end !== want.fend)
                begin
                    $error("field_end: expected %0b, actual %0b", want.fend, field_end);
                    mismatches++;
                end
                if (error_code !== want.ecode)
                begin
                    $error("error_code: expected %0d, actual %0d", want.ecode, error_code);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("length_prefixed_frame_parser: mismatch");
            $finish;
        end
    end

    initial
    begin
        body_limit = BODY_LIMIT_RESET;
        p_halted   = 1'b0;
        clear_frame();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_well_formed();
        test_broken_frames();
        test_length_limits();
        test_output_backpressure();
        test_back_to_back();

        // drain
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("length_prefixed_frame_parser: match");
        else
            $display("length_prefixed_frame_parser: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lpfp_pkg.sv
rtl/lpfp_regs.sv
rtl/lpfp_core.sv
rtl/lpfp_outq.sv
rtl/length_prefixed_frame_parser.sv
rtl/lpfp_chk.sv
dv/tb_top.sv
